// ===== rtl/pda_pkg.sv =====
package pda_pkg;

    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int DIST_W    = 10;
    localparam int SW_W      = 8;
    localparam int PAT_W     = 8;
    localparam int DIGIT_W   = 4;
    localparam int PERIOD_W  = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FAR   = 3'd0,
        REG_ZONE2 = 3'd1,
        REG_ZONE3 = 3'd2,
        REG_ZONE4 = 3'd3,
        REG_ZONE5 = 3'd4,
        REG_NEAR  = 3'd5,
        REG_MAX   = 3'd6,
        REG_MIN   = 3'd7
    } cfg_reg_t;

    localparam logic [DIST_W-1:0] CFG_RESET [NUM_REGS] = '{
        10'd200, 10'd180, 10'd120, 10'd80, 10'd50, 10'd20, 10'd400, 10'd2
    };

    localparam logic [SW_W-1:0]   SW_UP      = 8'h01;
    localparam logic [SW_W-1:0]   SW_DOWN    = 8'h02;
    localparam logic [DIST_W-1:0] DIST_RESET = 10'd3;
    localparam logic [PAT_W-1:0]  PAT_FAR    = 8'hFE;
    localparam logic [PAT_W-1:0]  PAT_NEAR   = 8'h01;

    typedef enum logic [2:0] {
        ZONE_FAR,
        ZONE_2,
        ZONE_3,
        ZONE_4,
        ZONE_5,
        ZONE_6,
        ZONE_NEAR
    } zone_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] hundreds;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] units;
    } digits_t;

    function automatic logic [PERIOD_W-1:0] zone_period(zone_t zone);
        logic [PERIOD_W-1:0] period;
        unique case (zone)
            ZONE_2:  period = 11'd1500;
            ZONE_3:  period = 11'd1000;
            ZONE_4:  period = 11'd500;
            ZONE_5:  period = 11'd375;
            ZONE_6:  period = 11'd250;
            default: period = '1;
        endcase
        return period;
    endfunction

    function automatic logic [PAT_W-1:0] zone_pattern(zone_t zone, logic phase);
        logic [PAT_W-1:0] pattern;
        unique case (zone)
            ZONE_FAR:  pattern = PAT_FAR;
            ZONE_2:    pattern = phase ? 8'hFD : 8'hFC;
            ZONE_3:    pattern = phase ? 8'hF7 : 8'hFE;
            ZONE_4:    pattern = phase ? 8'hFB : 8'hFE;
            ZONE_5:    pattern = phase ? 8'hEF : 8'hEE;
            ZONE_6:    pattern = phase ? 8'hF9 : 8'hF8;
            default:   pattern = PAT_NEAR;
        endcase
        return pattern;
    endfunction

endpackage

// ===== rtl/pda_digits.sv =====
module pda_digits (
    input  logic [pda_pkg::DIST_W-1:0] distance,
    output pda_pkg::digits_t           digits
);
    import pda_pkg::*;

    // reciprocal multiplies, exact for any 10-bit value
    logic [15:0] prod_100;
    logic [17:0] prod_10;
    logic [3:0]  quot_100;
    logic [6:0]  quot_10;
    logic [6:0]  quot_100_x10;
    logic [9:0]  quot_10_x10;
    logic [6:0]  tens_full;
    logic [9:0]  units_full;

    assign prod_100 = 16'(distance) * 16'd41;
    assign prod_10  = 18'(distance) * 18'd205;
    assign quot_100 = prod_100[15:12];
    assign quot_10  = prod_10[17:11];

    assign quot_100_x10 = {quot_100, 3'b000} + {2'b00, quot_100, 1'b0};
    assign quot_10_x10  = {quot_10, 3'b000} + {2'b00, quot_10, 1'b0};

    assign tens_full  = quot_10 - quot_100_x10;
    assign units_full = distance - quot_10_x10;

    assign digits.hundreds = quot_100;
    assign digits.tens     = tens_full[DIGIT_W-1:0];
    assign digits.units    = units_full[DIGIT_W-1:0];

endmodule

// ===== rtl/parking_distance_alarm_top.sv =====
// channel   signals                                        moves
// in        in_valid, in_ready, switch_port                one tick request
// out       out_valid, out_ready, alarm_pattern,           one result per request
//           distance_value, digit_hundreds/tens/units
// cfg       cfg_we, cfg_index, cfg_data                    register write, no wait
//
// one request per cycle sustained while out_ready stays high; a result passes through
// the stage-1 and output registers; the distance/timer/phase update and zone compare
// feed the first stage, the digit split takes the second stage
// reset restores register defaults, distance 3, timer and phase cleared
// a stalled output holds both stages; in_ready drops only when both are full
module parking_distance_alarm_top #(
    parameter int PERIOD_BITS = 11
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [pda_pkg::SW_W-1:0]        switch_port,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pda_pkg::PAT_W-1:0]       alarm_pattern,
    output logic [pda_pkg::DIST_W-1:0]      distance_value,
    output logic [pda_pkg::DIGIT_W-1:0]     digit_hundreds,
    output logic [pda_pkg::DIGIT_W-1:0]     digit_tens,
    output logic [pda_pkg::DIGIT_W-1:0]     digit_units,
    input  logic                            cfg_we,
    input  logic [pda_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pda_pkg::DIST_W-1:0]      cfg_data
);
    import pda_pkg::*;

    localparam int CMP_W = (PERIOD_BITS > PERIOD_W) ? PERIOD_BITS : PERIOD_W;
    localparam logic [PERIOD_BITS-1:0] ELAPSED_MAX = {PERIOD_BITS{1'b1}};

    logic [DIST_W-1:0]      cfg_reg [NUM_REGS];
    logic [DIST_W-1:0]      distance_reg, distance_next, distance_up;
    logic [PERIOD_BITS-1:0] elapsed_reg, elapsed_next;
    logic                   phase_reg, phase_next;

    logic                   s1_valid_reg, s1_valid_next;
    logic [PAT_W-1:0]       s1_pattern_reg;
    logic [DIST_W-1:0]      s1_distance_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [PAT_W-1:0]       out_pattern_reg;
    logic [DIST_W-1:0]      out_distance_reg;
    digits_t                out_digits_reg;

    logic                   in_fire, s1_advance;
    zone_t                  zone;
    logic [PAT_W-1:0]       pattern;
    logic                   period_hit;
    digits_t                digits;

    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    // distance step
    always_comb
    begin
        distance_up = distance_reg;
        if (switch_port == SW_UP && distance_reg < cfg_reg[REG_MAX])
        begin
            distance_up = distance_reg + 10'd1;
        end
        distance_next = distance_up;
        if (switch_port == SW_DOWN && distance_up > cfg_reg[REG_MIN])
        begin
            distance_next = distance_up - 10'd1;
        end
    end

    // zone cascade, first threshold exceeded wins
    always_comb
    begin
        if (distance_next > cfg_reg[REG_FAR])
            zone = ZONE_FAR;
        else if (distance_next > cfg_reg[REG_ZONE2])
            zone = ZONE_2;
        else if (distance_next > cfg_reg[REG_ZONE3])
            zone = ZONE_3;
        else if (distance_next > cfg_reg[REG_ZONE4])
            zone = ZONE_4;
        else if (distance_next > cfg_reg[REG_ZONE5])
            zone = ZONE_5;
        else if (distance_next > cfg_reg[REG_NEAR])
            zone = ZONE_6;
        else
            zone = ZONE_NEAR;
    end

    assign pattern    = zone_pattern(zone, phase_reg);
    assign period_hit = CMP_W'(elapsed_reg) >= CMP_W'(zone_period(zone));

    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        if (zone == ZONE_FAR || zone == ZONE_NEAR)
        begin
            phase_next   = 1'b0;
            elapsed_next = PERIOD_BITS'(1);
        end
        else if (period_hit)
        begin
            phase_next   = !phase_reg;
            elapsed_next = PERIOD_BITS'(1);
        end
        else if (elapsed_reg != ELAPSED_MAX)
        begin
            elapsed_next = elapsed_reg + PERIOD_BITS'(1);
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (s1_advance)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
            distance_reg  <= DIST_RESET;
            elapsed_reg   <= '0;
            phase_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end
            if (in_fire)
            begin
                distance_reg <= distance_next;
                elapsed_reg  <= elapsed_next;
                phase_reg    <= phase_next;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pattern_reg  <= pattern;
            s1_distance_reg <= distance_next;
        end
        if (s1_advance && s1_valid_reg)
        begin
            out_pattern_reg  <= s1_pattern_reg;
            out_distance_reg <= s1_distance_reg;
            out_digits_reg   <= digits;
        end
    end

    pda_digits u_digits (
        .distance (s1_distance_reg),
        .digits   (digits)
    );

    assign out_valid      = out_valid_reg;
    assign alarm_pattern  = out_pattern_reg;
    assign distance_value = out_distance_reg;
    assign digit_hundreds = out_digits_reg.hundreds;
    assign digit_tens     = out_digits_reg.tens;
    assign digit_units    = out_digits_reg.units;

endmodule

// ===== tb/parking_distance_alarm_top_tb.sv =====
module parking_distance_alarm_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pda_pkg::*;

    localparam int TICK_BITS     = 11;
    localparam int WATCHDOG_MAX  = 1000;
    localparam int SETTLE_CYCLES = 6;
    localparam int MODE_SPAN     = 470;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 60;

    localparam logic [SW_W-1:0]      SW_HOLD   = 8'h00;
    localparam logic [TICK_BITS-1:0] TICKS_MAX = {TICK_BITS{1'b1}};

    // blinking zones 2 to 6: period in ticks and pattern per buzzer phase
    localparam int BLINK_PERIOD [5] = '{1500, 1000, 500, 375, 250};
    localparam logic [PAT_W-1:0] BLINK_PAT [5][2] = '{
        '{8'hFC, 8'hFD},
        '{8'hFE, 8'hF7},
        '{8'hFE, 8'hFB},
        '{8'hEE, 8'hEF},
        '{8'hF8, 8'hF9}
    };

    typedef struct packed {
        logic [PAT_W-1:0]   pattern;
        logic [DIST_W-1:0]  distance;
        logic [DIGIT_W-1:0] hundreds;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] units;
    } tick_result_t;

    typedef struct packed {
        logic [SW_W-1:0] sw;
        logic            typed;
        logic            reconf;
        tick_result_t    res;
    } tick_row_t;

    // far, zone2, zone3, zone4, zone5, near, max, min
    localparam logic [DIST_W-1:0] COMPACT_SETTING [NUM_REGS] = '{
        10'd10, 10'd8, 10'd6, 10'd4, 10'd2, 10'd1, 10'd12, 10'd0
    };

    localparam int NUM_ROWS = 24;
    localparam tick_row_t DIRECTED [NUM_ROWS] = '{
        '{SW_HOLD, 1'b1, 1'b0, '{PAT_NEAR, 10'd3, 4'd0, 4'd0, 4'd3}},
        '{SW_UP,   1'b1, 1'b0, '{PAT_NEAR, 10'd4, 4'd0, 4'd0, 4'd4}},
        '{SW_DOWN, 1'b1, 1'b0, '{PAT_NEAR, 10'd3, 4'd0, 4'd0, 4'd3}},
        '{SW_DOWN, 1'b1, 1'b0, '{PAT_NEAR, 10'd2, 4'd0, 4'd0, 4'd2}},
        '{SW_DOWN, 1'b1, 1'b0, '{PAT_NEAR, 10'd2, 4'd0, 4'd0, 4'd2}},
        '{8'hFF,   1'b1, 1'b0, '{PAT_NEAR, 10'd2, 4'd0, 4'd0, 4'd2}},
        '{8'h03,   1'b1, 1'b0, '{PAT_NEAR, 10'd2, 4'd0, 4'd0, 4'd2}},
        '{8'h80,   1'b0, 1'b0, '0},
        '{SW_DOWN, 1'b0, 1'b1, '0},
        '{SW_DOWN, 1'b0, 1'b0, '0},
        '{SW_DOWN, 1'b0, 1'b0, '0},
        '{SW_UP,   1'b0, 1'b0, '0},
        '{SW_UP,   1'b0, 1'b0, '0},
        '{SW_UP,   1'b0, 1'b0, '0},
        '{SW_UP,   1'b0, 1'b0, '0},
        '{SW_UP,   1'b0, 1'b0, '0},
        '{SW_UP,   1'b0, 1'b0, '0},
        '{SW_UP,   1'b0, 1'b0, '0},
        '{SW_UP,   1'b0, 1'b0, '0},
        '{SW_UP,   1'b0, 1'b0, '0},
        '{SW_UP,   1'b0, 1'b0, '0},
        '{SW_UP,   1'b0, 1'b0, '0},
        '{SW_UP,   1'b0, 1'b0, '0},
        '{SW_UP,   1'b0, 1'b0, '0}
    };

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [SW_W-1:0]       switch_port = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [PAT_W-1:0]      alarm_pattern;
    logic [DIST_W-1:0]     distance_value;
    logic [DIGIT_W-1:0]    digit_hundreds;
    logic [DIGIT_W-1:0]    digit_tens;
    logic [DIGIT_W-1:0]    digit_units;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = REG_FAR;
    logic [DIST_W-1:0]     cfg_data    = '0;

    // tracked copy of the alarm state
    logic [DIST_W-1:0]     alarm_regs [NUM_REGS];
    logic [DIST_W-1:0]     track_distance;
    logic [TICK_BITS-1:0]  track_ticks;
    logic                  track_phase;

    tick_result_t          pending_results [$];
    int                    errors         = 0;
    int                    sent_count     = 0;
    int                    results_seen   = 0;
    int                    quiet_cycles   = 0;
    int                    long_hold_left = 0;
    bit                    long_hold_done = 1'b0;

    parking_distance_alarm_top #(
        .PERIOD_BITS(TICK_BITS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .switch_port    (switch_port),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .alarm_pattern  (alarm_pattern),
        .distance_value (distance_value),
        .digit_hundreds (digit_hundreds),
        .digit_tens     (digit_tens),
        .digit_units    (digit_units),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic tick_result_t predict_tick(input logic [SW_W-1:0] sw);
        tick_result_t r;
        zone_t        zone;
        int           slot;
        if (sw == SW_UP && track_distance < alarm_regs[REG_MAX])
            track_distance = track_distance + 1'b1;
        if (sw == SW_DOWN && track_distance > alarm_regs[REG_MIN])
            track_distance = track_distance - 1'b1;

        // top-down cascade, first exceeded threshold wins
        if (track_distance > alarm_regs[REG_FAR])
            zone = ZONE_FAR;
        else if (track_distance > alarm_regs[REG_ZONE2])
            zone = ZONE_2;
        else if (track_distance > alarm_regs[REG_ZONE3])
            zone = ZONE_3;
        else if (track_distance > alarm_regs[REG_ZONE4])
            zone = ZONE_4;
        else if (track_distance > alarm_regs[REG_ZONE5])
            zone = ZONE_5;
        else if (track_distance > alarm_regs[REG_NEAR])
            zone = ZONE_6;
        else
            zone = ZONE_NEAR;

        if (zone == ZONE_FAR || zone == ZONE_NEAR)
        begin
            r.pattern   = (zone == ZONE_FAR) ? PAT_FAR : PAT_NEAR;
            track_ticks = '0;
            track_phase = 1'b0;
        end
        else
        begin
            slot      = int'(zone) - int'(ZONE_2);
            r.pattern = BLINK_PAT[slot][track_phase];
            if (int'(track_ticks) >= BLINK_PERIOD[slot])
            begin
                track_ticks = '0;
                track_phase = ~track_phase;
            end
        end
        if (track_ticks < TICKS_MAX)
            track_ticks = track_ticks + 1'b1;

        r.distance = track_distance;
        r.hundreds = DIGIT_W'(track_distance / 100);
        r.tens     = DIGIT_W'((track_distance / 10) % 10);
        r.units    = DIGIT_W'(track_distance % 10);
        return r;
    endfunction

    function automatic int sender_idle_pct();
        if (sent_count < MODE_SPAN)
            return 21;
        else if (sent_count < 2 * MODE_SPAN)
            return 67;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (sent_count < MODE_SPAN)
            return 67;
        else if (sent_count < 2 * MODE_SPAN)
            return 21;
        return 0;
    endfunction

    function automatic logic [SW_W-1:0] pick_switch(input int up_pct, input int down_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < up_pct)
            return SW_UP;
        else if (roll < up_pct + down_pct)
            return SW_DOWN;
        else if ($urandom_range(1) == 1)
            return SW_W'($urandom);
        return SW_HOLD;
    endfunction

    // called at a rising edge, returns at the edge that accepts the request
    task automatic send_tick(input logic [SW_W-1:0] sw, input logic typed,
                             input tick_result_t typed_res);
        tick_result_t want;
        while ($urandom_range(99) < sender_idle_pct())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        switch_port <= sw;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = predict_tick(sw);
        pending_results.push_back(typed ? typed_res : want);
        sent_count <= sent_count + 1;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [DIST_W-1:0] vals [NUM_REGS]);
        wait_drained();
        for (int k = 0; k < NUM_REGS; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_reg_t'(k);
            cfg_data  <= vals[k];
            @(posedge clk);
            alarm_regs[k] = vals[k];
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input int count, input int up_pct, input int down_pct,
                             input bit climb);
        int k;
        k = 0;
        while (k < count || (climb && track_distance < alarm_regs[REG_MAX]))
        begin
            send_tick(pick_switch(up_pct, down_pct), 1'b0, '0);
            k++;
        end
    endtask

    task automatic check_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, what, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready      <= 1'b0;
            long_hold_left <= 0;
            long_hold_done <= 1'b0;
        end
        else if (long_hold_left != 0)
        begin
            out_ready      <= 1'b0;
            long_hold_left <= long_hold_left - 1;
        end
        else if (!long_hold_done && results_seen >= HOLD_AT)
        begin
            // long stall so the pipeline fills and backs up the request side
            out_ready      <= 1'b0;
            long_hold_left <= HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result with nothing pending, distance %0d",
                         $time, distance_value);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("alarm_pattern", want.pattern, alarm_pattern);
                check_field("distance_value", want.distance, distance_value);
                check_field("digit_hundreds", want.hundreds, digit_hundreds);
                check_field("digit_tens", want.tens, digit_tens);
                check_field("digit_units", want.units, digit_units);
            end
            results_seen <= results_seen + 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [DIST_W-1:0] setting [NUM_REGS];
        logic [DIST_W-1:0] pin;
        for (int k = 0; k < NUM_REGS; k++)
            alarm_regs[k] = CFG_RESET[k];
        track_distance = DIST_RESET;
        track_ticks    = '0;
        track_phase    = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < NUM_ROWS; k++)
        begin
            if (DIRECTED[k].reconf)
                apply_setting(COMPACT_SETTING);
            send_tick(DIRECTED[k].sw, DIRECTED[k].typed, DIRECTED[k].res);
        end

        // climb to the top limit across wide zones
        setting = '{560, 500, 420, 330, 200, 60, 599, 0};
        apply_setting(setting);
        run_phase(30, 96, 2, 1'b1);

        // walk near the top, narrow zones
        setting = '{595, 590, 585, 580, 575, 570, 599, 565};
        apply_setting(setting);
        run_phase(120, 40, 40, 1'b0);

        // distance pinned by equal limits, unordered thresholds, zone 3
        pin     = track_distance;
        setting = '{1023, pin, 0, 1023, 0, 1023, pin, pin};
        apply_setting(setting);
        run_phase(260, 30, 30, 1'b0);

        // same distance in zone 6, leftover count toggles at once
        setting = '{pin, pin, pin, 1023, pin, 0, pin, pin};
        apply_setting(setting);
        run_phase(270, 30, 30, 1'b0);

        for (int k = 0; k < NUM_REGS; k++)
            setting[k] = (k < int'(REG_MAX)) ? DIST_W'($urandom_range(1023))
                                             : DIST_W'($urandom_range(999));
        apply_setting(setting);
        run_phase(60, 35, 35, 1'b0);

        setting = '{0, 0, 0, 0, 0, 0, 0, 999};
        apply_setting(setting);
        run_phase(25, 40, 40, 1'b0);

        setting = '{1023, 1023, 1023, 1023, 1023, 1023, 999, 0};
        apply_setting(setting);
        run_phase(25, 10, 80, 1'b0);

        wait_drained();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
